// File: hdl/rcr_pkg.sv
package rcr_pkg;

    // pi in Q30 and one in Q30 for the sine series
    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

    // floor(2^32 / d) for the series divisors; estimate is at most one low
    localparam logic [31:0] RECIP_72 = 32'((64'd1 << 32) / 72);
    localparam logic [31:0] RECIP_42 = 32'((64'd1 << 32) / 42);
    localparam logic [31:0] RECIP_20 = 32'((64'd1 << 32) / 20);
    localparam logic [31:0] RECIP_6  = 32'((64'd1 << 32) / 6);

    // ray step is 1/200 of the Q1.14 direction; exact for 24-bit magnitudes
    localparam logic [24:0] STEP_RECIP = 25'(((64'd1 << 32) + 64'd199) / 64'd200);

    // configuration register indexes
    localparam logic [2:0] CFG_MAP_A     = 3'd0;
    localparam logic [2:0] CFG_MAP_B     = 3'd1;
    localparam logic [2:0] CFG_MAP_C     = 3'd2;
    localparam logic [2:0] CFG_MAP_D     = 3'd3;
    localparam logic [2:0] CFG_PLAYER_X  = 3'd4;
    localparam logic [2:0] CFG_PLAYER_Y  = 3'd5;
    localparam logic [2:0] CFG_VIEW      = 3'd6;
    localparam logic [2:0] CFG_MAX_STEPS = 3'd7;

    // characters
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_H     = 7'h48;
    localparam logic [6:0] CH_I     = 7'h49;
    localparam logic [6:0] CH_COLON = 7'h3A;
    localparam logic [6:0] CH_HASH  = 7'h23;
    localparam logic [6:0] CH_X     = 7'h78;
    localparam logic [6:0] CH_DOT   = 7'h2E;
    localparam logic [6:0] CH_DASH  = 7'h2D;

    // ray direction handed from front to back
    typedef struct packed {
        logic signed [15:0] s;
        logic signed [15:0] c;
    } t_ray;

    function automatic logic [6:0] series_div(input logic [1:0] k);
        logic [6:0] d;
        unique case (k)
            2'd0:    d = 7'd72;
            2'd1:    d = 7'd42;
            2'd2:    d = 7'd20;
            default: d = 7'd6;
        endcase
        return d;
    endfunction

    function automatic logic [31:0] series_recip(input logic [1:0] k);
        logic [31:0] r;
        unique case (k)
            2'd0:    r = RECIP_72;
            2'd1:    r = RECIP_42;
            2'd2:    r = RECIP_20;
            default: r = RECIP_6;
        endcase
        return r;
    endfunction

endpackage

// File: hdl/rcr_sine.sv
module rcr_sine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [15:0]        i_angle,
    output logic               o_done,
    output logic signed [15:0] o_sine
);

    localparam logic [2:0] SN_IDLE  = 3'd0;
    localparam logic [2:0] SN_X     = 3'd1;
    localparam logic [2:0] SN_X2    = 3'd2;
    localparam logic [2:0] SN_QEST  = 3'd3;
    localparam logic [2:0] SN_QFIX  = 3'd4;
    localparam logic [2:0] SN_NEXT  = 3'd5;
    localparam logic [2:0] SN_PROD  = 3'd6;
    localparam logic [2:0] SN_ROUND = 3'd7;

    logic [2:0]         r_state;
    logic [14:0]        r_arg;
    logic               r_neg;
    logic [31:0]        r_x, r_x2, r_num, r_qe, r_t, r_r;
    logic [1:0]         r_k;
    logic               r_done;
    logic signed [15:0] r_sine;

    logic [46:0] w_xp;
    logic [63:0] w_sq, w_est, w_np, w_rp;
    logic [31:0] w_rem, w_qf;
    logic [6:0]  w_d;
    logic [16:0] w_rnd;
    logic [15:0] w_mag;

    always_comb begin
        w_d   = rcr_pkg::series_div(r_k);
        w_xp  = 47'(r_arg) * 47'(rcr_pkg::PI_Q30);
        w_sq  = 64'(r_x) * 64'(r_x);
        w_est = 64'(r_num) * 64'(rcr_pkg::series_recip(r_k));
        w_rem = r_num - 32'(r_qe * 32'(w_d));
        w_qf  = r_qe + ((w_rem >= 32'(w_d)) ? 32'd1 : 32'd0);
        w_np  = 64'(r_x2) * 64'(r_t);
        w_rp  = 64'(r_x) * 64'(r_t);
        w_rnd = 17'((r_r + 32'h8000) >> 16);
        w_mag = (w_rnd > 17'd16384) ? 16'd16384 : w_rnd[15:0];
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        unique case (r_state)
            SN_IDLE: begin
                if (i_start) begin
                    r_arg   <= i_angle[14] ? (15'd16384 - {1'b0, i_angle[13:0]})
                                           : {1'b0, i_angle[13:0]};
                    r_neg   <= i_angle[15];
                    r_state <= SN_X;
                end
            end
            SN_X: begin
                r_x     <= w_xp[46:15];
                r_state <= SN_X2;
            end
            SN_X2: begin
                r_x2    <= w_sq[61:30];
                r_num   <= w_sq[61:30];
                r_k     <= 2'd0;
                r_state <= SN_QEST;
            end
            SN_QEST: begin
                r_qe    <= w_est[63:32];
                r_state <= SN_QFIX;
            end
            SN_QFIX: begin
                r_t <= rcr_pkg::ONE_Q30 - w_qf;
                if (r_k == 2'd3) begin
                    r_state <= SN_PROD;
                end else begin
                    r_k     <= r_k + 2'd1;
                    r_state <= SN_NEXT;
                end
            end
            SN_NEXT: begin
                r_num   <= w_np[61:30];
                r_state <= SN_QEST;
            end
            SN_PROD: begin
                r_r     <= w_rp[61:30];
                r_state <= SN_ROUND;
            end
            SN_ROUND: begin
                r_sine  <= r_neg ? -$signed(w_mag) : $signed(w_mag);
                r_done  <= 1'b1;
                r_state <= SN_IDLE;
            end
            default: r_state <= SN_IDLE;
        endcase
        if (!i_rst_n) begin
            r_state <= SN_IDLE;
            r_done  <= 1'b0;
        end
    end

    assign o_done = r_done;
    assign o_sine = r_sine;

endmodule

// File: hdl/rcr_front.sv
module rcr_front #(
    parameter int SCREEN_WIDTH  = 120,
    parameter int FIELD_OF_VIEW = 7822
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [6:0]          i_column,
    input  logic [15:0]         i_view_angle,
    output logic                o_push,
    output rcr_pkg::t_ray       o_ray,
    input  logic                i_full
);

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_MUL  = 3'd1;
    localparam logic [2:0] F_QUO  = 3'd2;
    localparam logic [2:0] F_SIN  = 3'd3;
    localparam logic [2:0] F_COS  = 3'd4;
    localparam logic [2:0] F_PUSH = 3'd5;

    localparam logic [14:0] FOV      = 15'(FIELD_OF_VIEW);
    localparam logic [15:0] HALF_FOV = 16'(FIELD_OF_VIEW / 2);
    // ceil(2^32 / width): exact quotient for 22-bit products
    localparam logic [32:0] WIDTH_RECIP =
        33'(((64'd1 << 32) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

    logic [2:0]    r_state;
    logic [6:0]    r_col;
    logic [21:0]   r_prod;
    logic [15:0]   r_ang;
    rcr_pkg::t_ray r_ray;

    logic [63:0]        w_quo;
    logic [15:0]        w_ang;
    logic               w_start;
    logic [15:0]        w_sine_ang;
    logic               w_done;
    logic signed [15:0] w_sine;

    always_comb begin
        w_quo      = (64'(r_prod) * 64'(WIDTH_RECIP)) >> 32;
        w_ang      = i_view_angle - HALF_FOV + w_quo[15:0];
        w_start    = (r_state == F_QUO) || (r_state == F_SIN && w_done);
        w_sine_ang = (r_state == F_QUO) ? w_ang : (r_ang + 16'h4000);
    end

    rcr_sine u_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_angle (w_sine_ang),
        .o_done  (w_done),
        .o_sine  (w_sine)
    );

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    r_col   <= i_column;
                    r_state <= F_MUL;
                end
            end
            F_MUL: begin
                r_prod  <= 22'(r_col) * 22'(FOV);
                r_state <= F_QUO;
            end
            F_QUO: begin
                r_ang   <= w_ang;
                r_state <= F_SIN;
            end
            F_SIN: begin
                if (w_done) begin
                    r_ray.s <= w_sine;
                    r_state <= F_COS;
                end
            end
            F_COS: begin
                if (w_done) begin
                    r_ray.c <= w_sine;
                    r_state <= F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) r_state <= F_IDLE;
            end
            default: r_state <= F_IDLE;
        endcase
        if (!i_rst_n) r_state <= F_IDLE;
    end

    assign o_ready = (r_state == F_IDLE);
    assign o_push  = (r_state == F_PUSH) && !i_full;
    assign o_ray   = r_ray;

endmodule

// File: hdl/rcr_queue.sv
module rcr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rcr_pkg::t_ray i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output rcr_pkg::t_ray o_data
);

    rcr_pkg::t_ray r_mem [2];
    logic          r_wr, r_rd;
    logic [1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
            r_wr        <= ~r_wr;
        end
        if (i_pop) r_rd <= ~r_rd;
        case ({i_push, i_pop})
            2'b10:   r_count <= r_count + 2'd1;
            2'b01:   r_count <= r_count - 2'd1;
            default: r_count <= r_count;
        endcase
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd];

endmodule

// File: hdl/rcr_back.sv
module rcr_back #(
    parameter int SCREEN_HEIGHT = 40,
    parameter int MAP_SIZE      = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ray_valid,
    input  rcr_pkg::t_ray i_ray,
    output logic          o_pop,
    input  logic [255:0]  i_map,
    input  logic [15:0]   i_player_x,
    input  logic [15:0]   i_player_y,
    input  logic [9:0]    i_max_steps,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [5:0]    o_row,
    output logic [6:0]    o_char,
    output logic          o_last
);

    localparam logic [2:0] B_IDLE   = 3'd0;
    localparam logic [2:0] B_MARCH  = 3'd1;
    localparam logic [2:0] B_DIST_A = 3'd2;
    localparam logic [2:0] B_DIST_B = 3'd3;
    localparam logic [2:0] B_TEST_A = 3'd4;
    localparam logic [2:0] B_TEST_B = 3'd5;
    localparam logic [2:0] B_DIV    = 3'd6;
    localparam logic [2:0] B_EMIT   = 3'd7;

    localparam logic [5:0]  LAST_ROW = 6'(SCREEN_HEIGHT - 1);
    localparam logic [5:0]  MAP_LIM  = 6'(MAP_SIZE);
    localparam logic [11:0] H12      = 12'(SCREEN_HEIGHT);
    localparam logic signed [15:0] H16 = 16'(SCREEN_HEIGHT);

    logic [2:0] r_state;

    // march pipeline: accumulators, then quotient, then cell evaluation
    logic signed [15:0] r_s, r_c;
    logic [9:0]         r_iss, r_n2, r_nhit;
    logic signed [25:0] r_acc_s, r_acc_c;
    logic               r_v1, r_v2;
    logic signed [17:0] r_q_s, r_q_c;
    logic [3:0]         r_hr, r_hc;

    // edge test
    logic [1:0]         r_ci, r_drop;
    logic [37:0]        r_sqx, r_sqy;
    logic [38:0]        r_best;
    logic signed [34:0] r_p1, r_p2, r_p3, r_p4;
    logic               r_edge;

    // roof divider
    logic [4:0]         r_dcnt;
    logic [15:0]        r_quo;
    logic [11:0]        r_rem;
    logic [10:0]        r_den;
    logic               r_dneg;
    logic signed [15:0] r_roof;

    // output
    logic [5:0] r_y;
    logic       r_ov;
    logic [5:0] r_row;
    logic [6:0] r_char;

    logic [25:0]        w_mag_s, w_mag_c;
    logic [49:0]        w_qm_s, w_qm_c;
    logic signed [18:0] w_px, w_py;
    logic               w_out;
    logic [3:0]         w_rx, w_cy;
    logic               w_wall;
    logic               w_issue;
    logic [4:0]         w_cx5, w_cy5;
    logic signed [18:0] w_vx, w_vy;
    logic [38:0]        w_d2;
    logic signed [35:0] w_dot, w_cr;
    logic [35:0]        w_cr_abs;
    logic [45:0]        w_crk;
    logic               w_hit_edge;
    logic signed [10:0] w_nm;
    logic signed [17:0] w_num;
    logic [15:0]        w_nmag;
    logic [11:0]        w_rsh;
    logic [6:0]         w_shade, w_ch;
    logic signed [15:0] w_ys, w_flr;
    logic [11:0]        w_k, w_n12;
    logic               w_load;

    always_comb begin
        // step offsets truncated toward zero
        w_mag_s = r_acc_s[25] ? 26'(-r_acc_s) : 26'(r_acc_s);
        w_mag_c = r_acc_c[25] ? 26'(-r_acc_c) : 26'(r_acc_c);
        w_qm_s  = (50'(w_mag_s[23:0]) * 50'(rcr_pkg::STEP_RECIP)) >> 32;
        w_qm_c  = (50'(w_mag_c[23:0]) * 50'(rcr_pkg::STEP_RECIP)) >> 32;

        w_px  = $signed({3'b0, i_player_x}) + $signed({r_q_s[17], r_q_s});
        w_py  = $signed({3'b0, i_player_y}) + $signed({r_q_c[17], r_q_c});
        // a coordinate in (-1, 0) still lands in cell 0
        w_out = (w_px <= -19'sd4096) || (w_py <= -19'sd4096)
             || (!w_px[18] && w_px[17:12] >= MAP_LIM)
             || (!w_py[18] && w_py[17:12] >= MAP_LIM);
        w_rx   = w_px[18] ? 4'd0 : w_px[15:12];
        w_cy   = w_py[18] ? 4'd0 : w_py[15:12];
        w_wall = i_map[{w_rx, w_cy}];
        w_issue = (r_state == B_MARCH) && (r_iss < i_max_steps);

        w_cx5 = {1'b0, r_hr} + {4'b0, r_ci[1]};
        w_cy5 = {1'b0, r_hc} + {4'b0, r_ci[0]};
        w_vx  = $signed({2'b0, w_cx5, 12'b0}) - $signed({3'b0, i_player_x});
        w_vy  = $signed({2'b0, w_cy5, 12'b0}) - $signed({3'b0, i_player_y});
        w_d2  = 39'(r_sqx) + 39'(r_sqy);

        w_dot      = 36'(r_p1) + 36'(r_p2);
        w_cr       = 36'(r_p3) - 36'(r_p4);
        w_cr_abs   = w_cr[35] ? 36'(-w_cr) : 36'(w_cr);
        w_crk      = 46'(w_cr_abs) * 46'd1000;
        w_hit_edge = (w_dot > 36'sd0) && (w_crk < 46'(w_dot[34:0]));

        w_nm   = $signed({1'b0, r_nhit}) - 11'sd100;
        w_num  = 18'(w_nm) * 18'(H16);
        w_nmag = w_num[17] ? 16'(-w_num) : 16'(w_num);
        w_rsh  = {r_rem[10:0], r_quo[15]};

        // wall shade by distance band
        w_n12 = 12'(r_nhit);
        if (r_edge)                                 w_shade = rcr_pkg::CH_SPACE;
        else if ({w_n12[9:0], 2'b0} <= 12'(i_max_steps)) w_shade = rcr_pkg::CH_ZERO;
        else if (w_n12 * 12'd3 < 12'(i_max_steps))  w_shade = rcr_pkg::CH_H;
        else if ({w_n12[10:0], 1'b0} < 12'(i_max_steps)) w_shade = rcr_pkg::CH_I;
        else if (w_n12 < 12'(i_max_steps))          w_shade = rcr_pkg::CH_COLON;
        else                                        w_shade = rcr_pkg::CH_SPACE;

        w_ys  = $signed({10'b0, r_y});
        w_flr = H16 - r_roof;
        w_k   = {H12[10:0], 1'b0} - {5'b0, r_y, 1'b0};
        if (w_ys <= r_roof)                      w_ch = rcr_pkg::CH_SPACE;
        else if (w_ys <= w_flr)                  w_ch = w_shade;
        else if ({w_k[9:0], 2'b0} < H12)         w_ch = rcr_pkg::CH_HASH;
        else if ({w_k[10:0], 1'b0} < H12)        w_ch = rcr_pkg::CH_X;
        else if ({w_k[9:0], 2'b0} < H12 * 12'd3) w_ch = rcr_pkg::CH_DOT;
        else if (w_k * 12'd10 < H12 * 12'd9)     w_ch = rcr_pkg::CH_DASH;
        else                                     w_ch = rcr_pkg::CH_SPACE;

        w_load = (r_state == B_EMIT) && (!r_ov || i_ready);
    end

    assign o_pop = (r_state == B_IDLE) && i_ray_valid;

    always_ff @(posedge i_clk) begin
        // march pipeline stages run every cycle
        r_v1 <= w_issue;
        if (w_issue) begin
            r_iss   <= r_iss + 10'd1;
            r_acc_s <= r_acc_s + 26'(r_s);
            r_acc_c <= r_acc_c + 26'(r_c);
        end
        r_v2  <= r_v1 && (r_state == B_MARCH);
        r_n2  <= r_iss;
        r_q_s <= r_acc_s[25] ? -18'(w_qm_s) : 18'(w_qm_s);
        r_q_c <= r_acc_c[25] ? -18'(w_qm_c) : 18'(w_qm_c);

        if (w_load) r_ov <= 1'b1;
        else if (i_ready) r_ov <= 1'b0;

        unique case (r_state)
            B_IDLE: begin
                if (i_ray_valid) begin
                    r_s     <= i_ray.s;
                    r_c     <= i_ray.c;
                    r_iss   <= 10'd0;
                    r_acc_s <= 26'sd0;
                    r_acc_c <= 26'sd0;
                    r_edge  <= 1'b0;
                    r_dcnt  <= 5'd0;
                    r_ci    <= 2'd0;
                    if (i_max_steps == 10'd0) begin
                        r_nhit  <= 10'd0;
                        r_state <= B_DIV;
                    end else begin
                        r_state <= B_MARCH;
                    end
                end
            end
            B_MARCH: begin
                if (r_v2) begin
                    if (w_out) begin
                        r_nhit  <= i_max_steps;
                        r_state <= B_DIV;
                    end else if (w_wall) begin
                        r_nhit  <= r_n2;
                        r_hr    <= w_rx;
                        r_hc    <= w_cy;
                        r_state <= B_DIST_A;
                    end else if (r_n2 == i_max_steps) begin
                        r_nhit  <= i_max_steps;
                        r_state <= B_DIV;
                    end
                end
            end
            B_DIST_A: begin
                r_sqx   <= 38'(w_vx) * 38'(w_vx);
                r_sqy   <= 38'(w_vy) * 38'(w_vy);
                r_state <= B_DIST_B;
            end
            B_DIST_B: begin
                // the farthest corner is dropped, the last one on a tie
                if (r_ci == 2'd0 || w_d2 >= r_best) begin
                    r_best <= w_d2;
                    r_drop <= r_ci;
                end
                r_ci    <= r_ci + 2'd1;
                r_state <= (r_ci == 2'd3) ? B_TEST_A : B_DIST_A;
            end
            B_TEST_A: begin
                if (r_ci == r_drop) begin
                    r_ci <= r_ci + 2'd1;
                    if (r_ci == 2'd3) r_state <= B_DIV;
                end else begin
                    r_p1    <= 35'(r_s) * 35'(w_vx);
                    r_p2    <= 35'(r_c) * 35'(w_vy);
                    r_p3    <= 35'(r_s) * 35'(w_vy);
                    r_p4    <= 35'(r_c) * 35'(w_vx);
                    r_state <= B_TEST_B;
                end
            end
            B_TEST_B: begin
                if (w_hit_edge) r_edge <= 1'b1;
                r_ci    <= r_ci + 2'd1;
                r_state <= (r_ci == 2'd3) ? B_DIV : B_TEST_A;
            end
            B_DIV: begin
                if (r_dcnt == 5'd0) begin
                    if (r_nhit == 10'd0) begin
                        r_roof  <= -(H16 + 16'sd1);
                        r_y     <= 6'd0;
                        r_state <= B_EMIT;
                    end else begin
                        r_quo  <= w_nmag;
                        r_dneg <= w_num[17];
                        r_den  <= {r_nhit, 1'b0};
                        r_rem  <= 12'd0;
                        r_dcnt <= 5'd1;
                    end
                end else if (r_dcnt == 5'd17) begin
                    r_roof  <= r_dneg ? -$signed(r_quo) : $signed(r_quo);
                    r_y     <= 6'd0;
                    r_state <= B_EMIT;
                end else begin
                    if (w_rsh >= 12'(r_den)) begin
                        r_rem <= w_rsh - 12'(r_den);
                        r_quo <= {r_quo[14:0], 1'b1};
                    end else begin
                        r_rem <= w_rsh;
                        r_quo <= {r_quo[14:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 5'd1;
                end
            end
            B_EMIT: begin
                if (w_load) begin
                    r_row  <= r_y;
                    r_char <= w_ch;
                    r_y    <= r_y + 6'd1;
                    if (r_y == LAST_ROW) r_state <= B_IDLE;
                end
            end
            default: r_state <= B_IDLE;
        endcase

        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end
    end

    assign o_valid = r_ov;
    assign o_row   = r_row;
    assign o_char  = r_char;
    assign o_last  = (r_row == LAST_ROW);

    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_y == LAST_ROW) |=> (r_state == B_IDLE && o_last && r_ov))
        else $error("last row did not close the column");

    a_div_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV && r_dcnt != 5'd0) |-> (r_den != 11'd0))
        else $error("roof divider running with zero divisor");

    a_drop_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_TEST_B) |-> ($past(r_ci) != r_drop))
        else $error("dropped corner was tested");

endmodule

// File: hdl/raycast_column_renderer.sv
// Raycasting column renderer for a text screen. Each input word carries a
// screen column; the block casts one ray over the wall map and returns
// SCREEN_HEIGHT output words, rows top to bottom, tlast on the bottom row.
// A front end turns the column into a ray angle and evaluates its sine and
// cosine with an iterative series unit, then queues the direction in a
// two-deep queue; the back end marches the ray one 0.02-unit step per cycle,
// runs a corner edge test on a wall hit, a roof divide, and then emits one
// row per cycle while the output is accepted. The front end works on the
// next column meanwhile. The user must write configuration through the plain
// write port while no column is in flight; the block itself does not
// enforce this.
module raycast_column_renderer #(
    parameter int SCREEN_WIDTH  = 120,
    parameter int SCREEN_HEIGHT = 40,
    parameter int MAP_SIZE      = 16,
    parameter int FIELD_OF_VIEW = 7822
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // column in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [6:0] column
    // characters out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [5:0] row, [12:6] char_code
    output logic        m_axis_tlast
);

    logic [63:0] r_map_a, r_map_b, r_map_c, r_map_d;
    logic [15:0] r_player_x, r_player_y, r_view;
    logic [9:0]  r_max_steps;

    always_ff @(posedge i_clk) begin
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                rcr_pkg::CFG_MAP_A:     r_map_a     <= i_cfg_data;
                rcr_pkg::CFG_MAP_B:     r_map_b     <= i_cfg_data;
                rcr_pkg::CFG_MAP_C:     r_map_c     <= i_cfg_data;
                rcr_pkg::CFG_MAP_D:     r_map_d     <= i_cfg_data;
                rcr_pkg::CFG_PLAYER_X:  r_player_x  <= i_cfg_data[15:0];
                rcr_pkg::CFG_PLAYER_Y:  r_player_y  <= i_cfg_data[15:0];
                rcr_pkg::CFG_VIEW:      r_view      <= i_cfg_data[15:0];
                rcr_pkg::CFG_MAX_STEPS: r_max_steps <= i_cfg_data[9:0];
                default: ;
            endcase
        end
        if (!i_rst_n) begin
            r_map_a     <= 64'd0;
            r_map_b     <= 64'd0;
            r_map_c     <= 64'd0;
            r_map_d     <= 64'd0;
            r_player_x  <= 16'd60211;
            r_player_y  <= 16'd20849;
            r_view      <= 16'd0;
            r_max_steps <= 10'd600;
        end
    end

    logic          w_push, w_full, w_pop, w_qvalid;
    rcr_pkg::t_ray w_ray_in, w_ray_out;
    logic [5:0]    w_row;
    logic [6:0]    w_char;

    rcr_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .FIELD_OF_VIEW (FIELD_OF_VIEW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_column     (s_axis_tdata[6:0]),
        .i_view_angle (r_view),
        .o_push       (w_push),
        .o_ray        (w_ray_in),
        .i_full       (w_full)
    );

    rcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_ray_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_data  (w_ray_out)
    );

    rcr_back #(
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .MAP_SIZE      (MAP_SIZE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ray_valid (w_qvalid),
        .i_ray       (w_ray_out),
        .o_pop       (w_pop),
        .i_map       ({r_map_d, r_map_c, r_map_b, r_map_a}),
        .i_player_x  (r_player_x),
        .i_player_y  (r_player_y),
        .i_max_steps (r_max_steps),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_row       (w_row),
        .o_char      (w_char),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b0, w_char, w_row};

endmodule
